@@ rtl/msa_pkg.sv @@
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the ascending merge sorter.
// ----------------------------------------------------------------------------
package msa_pkg;

	localparam int DATA_W        = 32;
	localparam int DEF_MAX_ITEMS = 64;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_RUN,
		S_MERGE,
		S_PREP,
		S_EMIT
	} state_t;

endpackage

@@ rtl/msa_in_if.sv @@
// ----------------------------------------------------------------------------
// msa_in_if
// Input channel of the merge sorter: one element and its final-element flag.
// ----------------------------------------------------------------------------
interface msa_in_if;
	logic          valid;
	logic          ready;
	msa_pkg::data_t value;
	logic          last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

@@ rtl/msa_out_if.sv @@
// ----------------------------------------------------------------------------
// msa_out_if
// Output channel of the merge sorter: one sorted element with its flags.
// ----------------------------------------------------------------------------
interface msa_out_if;
	logic           valid;
	logic           ready;
	msa_pkg::data_t sorted_value;
	logic           last_out;
	logic           dropped;

	modport source (output valid, output sorted_value, output last_out, output dropped,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input dropped,
		output ready);
endinterface

@@ rtl/msa_ram.sv @@
// ----------------------------------------------------------------------------
// msa_ram
// Element store with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module msa_ram #(
	parameter int DEPTH = msa_pkg::DEF_MAX_ITEMS,
	parameter int AW    = 6
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  msa_pkg::data_t wdata,
	input  logic [AW-1:0]  raddr0,
	input  logic [AW-1:0]  raddr1,
	output msa_pkg::data_t rdata0,
	output msa_pkg::data_t rdata1
);

	msa_pkg::data_t mem_q [DEPTH];
	msa_pkg::data_t rd0_q;
	msa_pkg::data_t rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd0_q <= mem_q[raddr0];
		rd1_q <= mem_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

@@ rtl/merge_sort_ascending.sv @@
// Sequence: items are taken in the load state. After the final item, each merge pass over n
// elements runs a setup state per run pair and then the merge state, for ceil(log2(n)) passes,
// followed by a prepare state and the emit state; results then leave one per cycle while the
// receiver is ready. Throughput: one sequence at a time, set by the single compare unit that
// writes one element per cycle between two stores.
// Reset: arst_n clears the fill count, overflow flag, sequencer and output valid.
// ----------------------------------------------------------------------------
// merge_sort_ascending
// Stable ascending merge sort of signed 32-bit elements using bottom-up passes
// that alternate between two stores, with one shared compare unit.
// ----------------------------------------------------------------------------
module merge_sort_ascending #(
	parameter int MAX_ITEMS = msa_pkg::DEF_MAX_ITEMS
) (
	input  logic      clk,
	input  logic      arst_n,
	msa_in_if.sink    items_in,
	msa_out_if.source items_out
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int EW = CW + 2;

	msa_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] l_q, l_d;
	logic [CW-1:0] r_q, r_d;
	logic [CW-1:0] d_q, d_d;
	logic [CW-1:0] w_q, w_d;
	logic          ov_q, ov_d;
	logic          src_b_q, src_b_d;

	logic           out_valid_q;
	msa_pkg::data_t out_value_q;
	logic           out_last_q;
	logic           out_drop_q;
	logic           load_out;
	logic           emit_last;

	logic           we_a, we_b;
	logic [AW-1:0]  waddr, raddr0, raddr1;
	msa_pkg::data_t wdata;
	msa_pkg::data_t a_rd0, a_rd1, b_rd0, b_rd1;
	msa_pkg::data_t rd_l, rd_r;

	logic [EW-1:0] lo_w, hi_w, n_w, w2_w;
	logic [CW-1:0] mid_c, hi_c, l_n, r_n, d_n;
	logic          l_ok, r_ok, take_l;

	msa_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
		.raddr0(raddr0), .raddr1(raddr1), .rdata0(a_rd0), .rdata1(a_rd1)
	);

	msa_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
		.raddr0(raddr0), .raddr1(raddr1), .rdata0(b_rd0), .rdata1(b_rd1)
	);

	assign rd_l = src_b_q ? b_rd0 : a_rd0;
	assign rd_r = src_b_q ? b_rd1 : a_rd1;

	assign n_w  = {2'b00, cnt_q};
	assign lo_w = {2'b00, lo_q} + {2'b00, w_q};
	assign hi_w = lo_w + {2'b00, w_q};
	assign w2_w = {w_q, 2'b00} >> 1;
	assign mid_c = (lo_w > n_w) ? cnt_q : lo_w[CW-1:0];
	assign hi_c  = (hi_w > n_w) ? cnt_q : hi_w[CW-1:0];

	assign l_ok   = l_q < mid_q;
	assign r_ok   = r_q < hi_q;
	assign take_l = l_ok && (!r_ok || (rd_l <= rd_r));
	assign l_n    = take_l ? l_q + CW'(1) : l_q;
	assign r_n    = take_l ? r_q : r_q + CW'(1);
	assign d_n    = d_q + CW'(1);

	assign items_in.ready = (state_q == msa_pkg::S_LOAD);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lo_d      = lo_q;
		mid_d     = mid_q;
		hi_d      = hi_q;
		l_d       = l_q;
		r_d       = r_q;
		d_d       = d_q;
		w_d       = w_q;
		ov_d      = ov_q;
		src_b_d   = src_b_q;
		we_a      = 1'b0;
		we_b      = 1'b0;
		waddr     = d_q[AW-1:0];
		wdata     = rd_l;
		raddr0    = '0;
		raddr1    = '0;
		load_out  = 1'b0;
		emit_last = 1'b0;

		unique case (state_q)
			msa_pkg::S_LOAD: begin
				if (items_in.valid) begin
					if (cnt_q < CW'(MAX_ITEMS)) begin
						we_a  = 1'b1;
						waddr = cnt_q[AW-1:0];
						wdata = items_in.value;
						cnt_d = cnt_q + CW'(1);
					end else begin
						ov_d = 1'b1;
					end
					if (items_in.last) begin
						lo_d    = '0;
						w_d     = CW'(1);
						src_b_d = 1'b0;
						state_d = (cnt_d > CW'(1)) ? msa_pkg::S_RUN : msa_pkg::S_PREP;
					end
				end
			end
			msa_pkg::S_RUN: begin
				l_d     = lo_q;
				r_d     = mid_c;
				d_d     = lo_q;
				mid_d   = mid_c;
				hi_d    = hi_c;
				raddr0  = lo_q[AW-1:0];
				raddr1  = mid_c[AW-1:0];
				state_d = msa_pkg::S_MERGE;
			end
			msa_pkg::S_MERGE: begin
				we_a   = src_b_q;
				we_b   = !src_b_q;
				waddr  = d_q[AW-1:0];
				wdata  = take_l ? rd_l : rd_r;
				raddr0 = l_n[AW-1:0];
				raddr1 = r_n[AW-1:0];
				l_d    = l_n;
				r_d    = r_n;
				d_d    = d_n;
				if (d_n == hi_q) begin
					lo_d    = hi_q;
					state_d = msa_pkg::S_RUN;
					if (hi_q == cnt_q) begin
						src_b_d = !src_b_q;
						lo_d    = '0;
						if (w2_w >= n_w) begin
							state_d = msa_pkg::S_PREP;
						end else begin
							w_d = w2_w[CW-1:0];
						end
					end
				end
			end
			msa_pkg::S_PREP: begin
				raddr0  = '0;
				d_d     = '0;
				state_d = msa_pkg::S_EMIT;
			end
			msa_pkg::S_EMIT: begin
				raddr0 = d_q[AW-1:0];
				if (!out_valid_q || items_out.ready) begin
					load_out  = 1'b1;
					emit_last = (d_n == cnt_q);
					raddr0    = d_n[AW-1:0];
					d_d       = d_n;
					if (emit_last) begin
						cnt_d   = '0;
						ov_d    = 1'b0;
						state_d = msa_pkg::S_LOAD;
					end
				end
			end
			default: begin
				state_d = msa_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msa_pkg::S_LOAD;
			cnt_q       <= '0;
			ov_q        <= 1'b0;
			src_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
			src_b_q <= src_b_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (items_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		mid_q <= mid_d;
		hi_q  <= hi_d;
		l_q   <= l_d;
		r_q   <= r_d;
		d_q   <= d_d;
		w_q   <= w_d;
		if (load_out) begin
			out_value_q <= rd_l;
			out_last_q  <= emit_last;
			out_drop_q  <= ov_q;
		end
	end

	assign items_out.valid        = out_valid_q;
	assign items_out.sorted_value = out_value_q;
	assign items_out.last_out     = out_last_q;
	assign items_out.dropped      = out_drop_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("Fill count exceeds the store depth.");

	a_merge_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msa_pkg::S_MERGE) |-> (d_q < hi_q) && (hi_q <= cnt_q))
		else $error("Merge write lies outside the current run pair.");

	a_merge_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msa_pkg::S_MERGE) |-> (l_ok || r_ok))
		else $error("Merge step has no element left in either run.");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msa_pkg::S_EMIT) |-> (d_q < cnt_q))
		else $error("Emit pointer ran past the element count.");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && emit_last) |=> (cnt_q == '0) && !ov_q
			&& (state_q == msa_pkg::S_LOAD))
		else $error("Final item did not return the block to loading.");

endmodule
